// File: rtl/pprb_pkg.sv
// Package for the ping-pong packet ring buffer.
// Holds ring geometry, derived widths, the stored entry layout and action codes.
// No dependencies.
`default_nettype none

package pprb_pkg;

    localparam int unsigned RING_DEPTH = 64;
    localparam int unsigned SLOTS      = 2 * RING_DEPTH;
    localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
    localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int unsigned ADDR_W     = $clog2(SLOTS);

    localparam logic [15:0] TALLY_MAX  = 16'hFFFF;

    localparam logic ACT_ARRIVAL = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic [7:0]  kind;
        logic [11:0] length;
        logic [15:0] tag;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/ping_pong_packet_ring_buffer.sv
// Ping-pong packet ring buffer: two rings of packet descriptors in one memory.
// Depends on pprb_pkg for geometry, widths, entry layout and action codes.
// Items pass in order through an input register, pointer logic with a single
// memory access, and a result register. Throughput: one item per cycle while
// no read is held up by out_stall; a held read stalls the input (in_stall).
// Reset clears pointers, counts, tallies, side flags and own_address; the
// entry memory is not cleared and needs no clearing pass.
`default_nettype none

module ping_pong_packet_ring_buffer
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic        action,
    input  wire logic [31:0] source_address,
    input  wire logic [7:0]  pdu_kind,
    input  wire logic [11:0] pdu_length,
    input  wire logic [15:0] payload_tag,
    input  wire logic        force_swap,

    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic        read_valid,
    output      logic [7:0]  out_kind,
    output      logic [11:0] out_length,
    output      logic [15:0] out_tag,
    output      logic [15:0] overwritten_count,

    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [31:0] cfg_data
);

    localparam pprb_pkg::cnt_t               DEPTH_CNT = pprb_pkg::CNT_W'(pprb_pkg::RING_DEPTH);
    localparam logic [pprb_pkg::PTR_W:0]     DEPTH_EXT = (pprb_pkg::PTR_W + 1)'(pprb_pkg::RING_DEPTH);
    localparam pprb_pkg::addr_t              SIDE_BASE = pprb_pkg::ADDR_W'(pprb_pkg::RING_DEPTH);

    // Input register.
    logic                 a_valid_reg;
    logic                 a_action_reg;
    logic [31:0]          a_src_reg;
    pprb_pkg::entry_t     a_entry_reg;
    logic                 a_force_reg;

    // Ring state.
    logic                 write_side_reg,      write_side_next;
    logic                 swap_pending_reg,    swap_pending_next;
    pprb_pkg::ptr_t       pub_oldest_reg [2];
    pprb_pkg::ptr_t       pub_oldest_next [2];
    pprb_pkg::cnt_t       entry_count_reg [2];
    pprb_pkg::cnt_t       entry_count_next [2];
    logic [15:0]          loss_tally_reg [2];
    logic [15:0]          loss_tally_next [2];
    pprb_pkg::ptr_t       writer_oldest_reg,   writer_oldest_next;
    pprb_pkg::ptr_t       writer_next_reg,     writer_next_next;
    logic                 writer_wrapped_reg,  writer_wrapped_next;
    logic [31:0]          own_address_reg;

    // Result register.
    logic                 out_valid_reg,       out_valid_next;
    logic                 read_valid_reg,      read_valid_next;
    logic [15:0]          loss_out_reg,        loss_out_next;
    pprb_pkg::entry_t     rdata_reg;

    pprb_pkg::entry_t     entry_mem [pprb_pkg::SLOTS];

    logic                 a_go;
    logic                 mem_we;
    pprb_pkg::addr_t      mem_waddr;
    logic                 mem_re;
    pprb_pkg::addr_t      mem_raddr;

    // Working values of the current item.
    logic                 ws;
    pprb_pkg::cnt_t       cnt_w;
    logic [15:0]          loss_w;
    pprb_pkg::ptr_t       wo_w;
    pprb_pkg::ptr_t       wn_w;
    logic                 wr_w;
    logic [pprb_pkg::PTR_W:0] nx;
    logic [pprb_pkg::PTR_W:0] nx_plus;
    logic                 side1;
    logic                 empty1;
    logic                 side2;
    logic                 rd;
    pprb_pkg::ptr_t       po_rd;

    assign a_go      = a_valid_reg && (a_action_reg == pprb_pkg::ACT_ARRIVAL
                                       || !out_valid_reg || !out_stall);
    assign in_stall  = a_valid_reg && !a_go;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        write_side_next     = write_side_reg;
        swap_pending_next   = swap_pending_reg;
        pub_oldest_next     = pub_oldest_reg;
        entry_count_next    = entry_count_reg;
        loss_tally_next     = loss_tally_reg;
        writer_oldest_next  = writer_oldest_reg;
        writer_next_next    = writer_next_reg;
        writer_wrapped_next = writer_wrapped_reg;
        out_valid_next      = out_valid_reg && out_stall;
        read_valid_next     = read_valid_reg;
        loss_out_next       = loss_out_reg;
        mem_we              = 1'b0;
        mem_re              = 1'b0;

        // Arrival side: a pending swap makes the write ring look freshly cleared.
        ws      = write_side_reg;
        cnt_w   = swap_pending_reg ? '0 : entry_count_reg[ws];
        loss_w  = swap_pending_reg ? '0 : loss_tally_reg[ws];
        wo_w    = swap_pending_reg ? '0 : writer_oldest_reg;
        wn_w    = swap_pending_reg ? '0 : writer_next_reg;
        wr_w    = swap_pending_reg ? 1'b0 : writer_wrapped_reg;
        nx      = {1'b0, wn_w} + 1'b1;
        nx_plus = nx + 1'b1;
        mem_waddr = ws ? (SIDE_BASE + pprb_pkg::ADDR_W'(wn_w)) : pprb_pkg::ADDR_W'(wn_w);

        // Read side: optional forced swap, then a swap when the read ring is empty.
        side1  = write_side_reg ^ a_force_reg;
        empty1 = (entry_count_reg[~side1] == '0);
        side2  = empty1 ? ~side1 : side1;
        rd     = ~side2;
        po_rd  = pub_oldest_reg[rd];
        mem_raddr = rd ? (SIDE_BASE + pprb_pkg::ADDR_W'(po_rd)) : pprb_pkg::ADDR_W'(po_rd);

        if (a_go)
        begin
            if (a_action_reg == pprb_pkg::ACT_ARRIVAL)
            begin
                if (a_entry_reg.length != '0 && a_src_reg != own_address_reg)
                begin
                    mem_we               = 1'b1;
                    swap_pending_next    = 1'b0;
                    pub_oldest_next[ws]  = wo_w;
                    entry_count_next[ws] = cnt_w;
                    loss_tally_next[ws]  = loss_w;
                    writer_oldest_next   = wo_w;
                    writer_wrapped_next  = wr_w;
                    writer_next_next     = nx[pprb_pkg::PTR_W-1:0];
                    if (!wr_w)
                    begin
                        if (cnt_w < DEPTH_CNT)
                        begin
                            entry_count_next[ws] = cnt_w + 1'b1;
                        end
                        if (nx >= DEPTH_EXT)
                        begin
                            writer_next_next    = '0;
                            writer_oldest_next  = pprb_pkg::PTR_W'(1);
                            writer_wrapped_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (nx >= DEPTH_EXT)
                        begin
                            writer_next_next   = '0;
                            writer_oldest_next = pprb_pkg::PTR_W'(1);
                        end
                        else if (nx_plus >= DEPTH_EXT)
                        begin
                            writer_oldest_next = '0;
                        end
                        else
                        begin
                            writer_oldest_next = nx_plus[pprb_pkg::PTR_W-1:0];
                        end
                        if (loss_w != pprb_pkg::TALLY_MAX)
                        begin
                            loss_tally_next[ws] = loss_w + 1'b1;
                        end
                    end
                end
            end
            else
            begin
                out_valid_next    = 1'b1;
                write_side_next   = side2;
                swap_pending_next = swap_pending_reg | a_force_reg | empty1;
                if (entry_count_reg[rd] == '0)
                begin
                    read_valid_next = 1'b0;
                    loss_out_next   = '0;
                end
                else
                begin
                    mem_re               = 1'b1;
                    read_valid_next      = 1'b1;
                    loss_out_next        = loss_tally_reg[rd];
                    entry_count_next[rd] = entry_count_reg[rd] - 1'b1;
                    // Taking the last entry hands this ring back to the writer.
                    if (entry_count_reg[rd] == pprb_pkg::CNT_W'(1))
                    begin
                        write_side_next   = ~side2;
                        swap_pending_next = 1'b1;
                    end
                    else if ({1'b0, po_rd} + 1'b1 >= DEPTH_EXT)
                    begin
                        pub_oldest_next[rd] = '0;
                    end
                    else
                    begin
                        pub_oldest_next[rd] = po_rd + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg        <= 1'b0;
            write_side_reg     <= 1'b0;
            swap_pending_reg   <= 1'b0;
            pub_oldest_reg     <= '{default: '0};
            entry_count_reg    <= '{default: '0};
            loss_tally_reg     <= '{default: '0};
            writer_oldest_reg  <= '0;
            writer_next_reg    <= '0;
            writer_wrapped_reg <= 1'b0;
            own_address_reg    <= '0;
            out_valid_reg      <= 1'b0;
            read_valid_reg     <= 1'b0;
            loss_out_reg       <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                a_valid_reg <= in_valid;
            end
            if (cfg_valid && cfg_ready)
            begin
                own_address_reg <= cfg_data;
            end
            write_side_reg     <= write_side_next;
            swap_pending_reg   <= swap_pending_next;
            pub_oldest_reg     <= pub_oldest_next;
            entry_count_reg    <= entry_count_next;
            loss_tally_reg     <= loss_tally_next;
            writer_oldest_reg  <= writer_oldest_next;
            writer_next_reg    <= writer_next_next;
            writer_wrapped_reg <= writer_wrapped_next;
            out_valid_reg      <= out_valid_next;
            read_valid_reg     <= read_valid_next;
            loss_out_reg       <= loss_out_next;
        end
    end

    // Input payload register; loads whenever the stage can take an item.
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            a_action_reg       <= action;
            a_src_reg          <= source_address;
            a_entry_reg.kind   <= pdu_kind;
            a_entry_reg.length <= pdu_length;
            a_entry_reg.tag    <= payload_tag;
            a_force_reg        <= force_swap;
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= a_entry_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= entry_mem[mem_raddr];
        end
    end

    assign out_valid         = out_valid_reg;
    assign read_valid        = read_valid_reg;
    assign out_kind          = read_valid_reg ? rdata_reg.kind   : '0;
    assign out_length        = read_valid_reg ? rdata_reg.length : '0;
    assign out_tag           = read_valid_reg ? rdata_reg.tag    : '0;
    assign overwritten_count = loss_out_reg;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the ping-pong packet ring buffer: directed items, random
// traffic, own-address changes and a long output hold-off.
// Depends on pprb_pkg and ping_pong_packet_ring_buffer.
module tb_top;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int REPORT_CAP    = 100;

    typedef struct packed {
        logic        action;
        logic [31:0] src;
        logic [7:0]  kind;
        logic [11:0] len;
        logic [15:0] tag;
        logic        force_swap;
    } ring_item_t;

    typedef struct packed {
        logic        read_valid;
        logic [7:0]  kind;
        logic [11:0] length;
        logic [15:0] tag;
        logic [15:0] lost;
    } ring_result_t;

    typedef struct packed {
        ring_item_t it;
        logic       typed;
    } plan_row_t;

    // What a read returns when both rings are empty.
    localparam ring_result_t NOTHING_READ = '0;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [31:0] source_address;
    logic [7:0]  pdu_kind;
    logic [11:0] pdu_length;
    logic [15:0] payload_tag;
    logic        force_swap;
    logic        out_valid;
    logic        out_stall;
    logic        read_valid;
    logic [7:0]  out_kind;
    logic [11:0] out_length;
    logic [15:0] out_tag;
    logic [15:0] overwritten_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    ping_pong_packet_ring_buffer dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .source_address    (source_address),
        .pdu_kind          (pdu_kind),
        .pdu_length        (pdu_length),
        .payload_tag       (payload_tag),
        .force_swap        (force_swap),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .read_valid        (read_valid),
        .out_kind          (out_kind),
        .out_length        (out_length),
        .out_tag           (out_tag),
        .overwritten_count (overwritten_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    // Predicted copy of the block's state.
    pprb_pkg::entry_t ring_mem [pprb_pkg::SLOTS];
    bit          wside;
    bit          swap_pend;
    int unsigned pub_oldest [2];
    int unsigned fill [2];
    int unsigned lost_tally [2];
    int unsigned w_oldest;
    int unsigned w_next;
    bit          w_wrapped;
    logic [31:0] own_addr_q;

    ring_result_t pending_reads [$];
    ring_result_t oldest_read;
    plan_row_t    plan [$];
    int           mismatches;
    int           live_items;
    int           cycle_count;
    bit           no_gaps;
    bit           hold_req;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic void flip_sides();
        wside     = ~wside;
        swap_pend = 1'b1;
    endfunction

    function automatic void store_packet(input ring_item_t it);
        int unsigned      ws;
        int unsigned      nx;
        pprb_pkg::entry_t e;
        ws = wside;
        if (swap_pend)
        begin
            fill[ws]       = 0;
            lost_tally[ws] = 0;
            w_oldest       = 0;
            w_next         = 0;
            w_wrapped      = 1'b0;
            swap_pend      = 1'b0;
        end
        e.kind   = it.kind;
        e.length = it.len;
        e.tag    = it.tag;
        ring_mem[ws * pprb_pkg::RING_DEPTH + w_next] = e;
        pub_oldest[ws] = w_oldest;
        nx = w_next + 1;
        if (!w_wrapped)
        begin
            if (fill[ws] < pprb_pkg::RING_DEPTH)
                fill[ws]++;
            if (nx >= pprb_pkg::RING_DEPTH)
            begin
                nx        = 0;
                w_oldest  = 1;
                w_wrapped = 1'b1;
            end
        end
        else
        begin
            // Once wrapped, every arrival pushes out the oldest entry.
            w_oldest = nx + 1;
            if (w_oldest >= pprb_pkg::RING_DEPTH)
                w_oldest = 0;
            if (nx >= pprb_pkg::RING_DEPTH)
            begin
                nx       = 0;
                w_oldest = 1;
            end
            if (lost_tally[ws] < 65535)
                lost_tally[ws]++;
        end
        w_next = nx;
    endfunction

    // Returns 1 when the item yields a result, which is then placed in res.
    function automatic bit predict_read(input ring_item_t it, output ring_result_t res);
        int unsigned      rs;
        pprb_pkg::entry_t e;
        res = NOTHING_READ;
        if (it.action == pprb_pkg::ACT_ARRIVAL)
        begin
            if (it.len != 0 && it.src != own_addr_q)
                store_packet(it);
            return 1'b0;
        end
        if (it.force_swap)
            flip_sides();
        rs = (wside == 1'b0) ? 1 : 0;
        if (fill[rs] == 0)
        begin
            flip_sides();
            rs = (wside == 1'b0) ? 1 : 0;
            if (fill[rs] == 0)
                return 1'b1;
        end
        e = ring_mem[rs * pprb_pkg::RING_DEPTH + pub_oldest[rs]];
        res.read_valid = 1'b1;
        res.kind       = e.kind;
        res.length     = e.length;
        res.tag        = e.tag;
        res.lost       = 16'(lost_tally[rs]);
        fill[rs]--;
        if (fill[rs] == 0)
            flip_sides();
        else
            pub_oldest[rs] = (pub_oldest[rs] + 1) % pprb_pkg::RING_DEPTH;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic ring_item_t make_arrival();
        ring_item_t it;
        int         r;
        it.action     = pprb_pkg::ACT_ARRIVAL;
        it.src        = $urandom;
        it.kind       = 8'($urandom_range(0, 255));
        it.tag        = 16'($urandom_range(0, 65535));
        it.force_swap = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 85)
            it.len = 12'($urandom_range(1, 2048));
        else if (r < 92)
            it.len = 12'($urandom_range(2049, 4095));
        else
            it.len = '0;
        if ($urandom_range(0, 19) == 0)
            it.src = own_addr_q;
        return it;
    endfunction

    function automatic ring_item_t make_read(input logic fs);
        ring_item_t it;
        it            = make_arrival();
        it.action     = pprb_pkg::ACT_READ;
        it.force_swap = fs;
        return it;
    endfunction

    function automatic void add_row(input logic act, input logic [31:0] src,
                                    input logic [7:0] kind, input logic [11:0] len,
                                    input logic [15:0] tag, input logic fs,
                                    input logic typed);
        plan_row_t row;
        row.it    = '{act, src, kind, len, tag, fs};
        row.typed = typed;
        plan.push_back(row);
    endfunction

    // Offers one item after a random gap and records its prediction at acceptance.
    task automatic push_item(input ring_item_t it, input logic typed);
        int           gap;
        ring_result_t res;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        action         <= it.action;
        source_address <= it.src;
        pdu_kind       <= it.kind;
        pdu_length     <= it.len;
        payload_tag    <= it.tag;
        force_swap     <= it.force_swap;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (it.action == pprb_pkg::ACT_READ || (it.len != 0 && it.src != own_addr_q))
            live_items++;
        if (predict_read(it, res))
            pending_reads.push_back(typed ? NOTHING_READ : res);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        // Arrivals give no result, so let the pipeline empty out as well.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_own_address(input logic [31:0] value);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        own_addr_q = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_traffic(input int n);
        int         target;
        int         r;
        int         burst;
        int         k;
        ring_item_t it;
        target = live_items + n;
        while (live_items < target)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                // Long bursts wrap the ring and exercise the overwrite path.
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90)
                                                    : $urandom_range(1, 20);
                for (k = 0; k < burst; k++)
                    push_item(make_arrival(), 1'b0);
            end
            else if (r < 85)
            begin
                burst = $urandom_range(1, 20);
                for (k = 0; k < burst; k++)
                    push_item(make_read(1'($urandom_range(0, 6) == 0)), 1'b0);
            end
            else
            begin
                burst = $urandom_range(1, 3);
                for (k = 0; k < burst; k++)
                begin
                    it        = make_arrival();
                    it.action = 1'($urandom_range(0, 1));
                    it.len    = 12'($urandom_range(0, 4095));
                    push_item(it, 1'b0);
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reads.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $error("result item with no read waiting for it");
            end
            else
            begin
                oldest_read = pending_reads.pop_front();
                check_field("read_valid", 32'(oldest_read.read_valid), 32'(read_valid));
                check_field("out_kind", 32'(oldest_read.kind), 32'(out_kind));
                check_field("out_length", 32'(oldest_read.length), 32'(out_length));
                check_field("out_tag", 32'(oldest_read.tag), 32'(out_tag));
                check_field("overwritten_count", 32'(oldest_read.lost),
                            32'(overwritten_count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Output side: random stall runs and a long hold-off on request.
    initial
    begin
        int run;
        bit level;
        out_stall = 1'b0;
        run       = 0;
        level     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                level    = 1'b1;
                run      = HOLD_CYCLES;
            end
            else if (run <= 0)
            begin
                if ($urandom_range(0, 99) < 40)
                begin
                    level = 1'b0;
                    run   = $urandom_range(1, 30);
                end
                else
                begin
                    level = 1'b1;
                    run   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 3);
                end
            end
            out_stall <= level;
            run--;
        end
    end

    initial
    begin
        int         k;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = pprb_pkg::ACT_ARRIVAL;
        source_address = '0;
        pdu_kind       = '0;
        pdu_length     = '0;
        payload_tag    = '0;
        force_swap     = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        own_addr_q     = '0;
        wside          = 1'b0;
        swap_pend      = 1'b0;
        pub_oldest     = '{0, 0};
        fill           = '{0, 0};
        lost_tally     = '{0, 0};
        w_oldest       = 0;
        w_next         = 0;
        w_wrapped      = 1'b0;
        mismatches     = 0;
        live_items     = 0;
        cycle_count    = 0;

        // Directed items, with own_address still at its reset value of zero.
        add_row(pprb_pkg::ACT_READ,    32'h0000_0000, 8'h00, 12'd0,    16'h0000, 1'b0, 1'b1);
        add_row(pprb_pkg::ACT_READ,    32'h0000_0000, 8'h00, 12'd0,    16'h0000, 1'b1, 1'b1);
        add_row(pprb_pkg::ACT_ARRIVAL, 32'h0000_0000, 8'h11, 12'd5,    16'h1111, 1'b0, 1'b0);
        add_row(pprb_pkg::ACT_ARRIVAL, 32'h0000_0001, 8'h22, 12'd0,    16'h2222, 1'b0, 1'b0);
        add_row(pprb_pkg::ACT_READ,    32'hFFFF_FFFF, 8'hFF, 12'hFFF,  16'hFFFF, 1'b0, 1'b1);
        add_row(pprb_pkg::ACT_ARRIVAL, 32'hFFFF_FFFF, 8'hFF, 12'd2048, 16'hFFFF, 1'b1, 1'b0);
        add_row(pprb_pkg::ACT_ARRIVAL, 32'h0000_0001, 8'h00, 12'd1,    16'h0000, 1'b0, 1'b0);
        add_row(pprb_pkg::ACT_ARRIVAL, 32'h1234_5678, 8'h5A, 12'hFFF,  16'hA5A5, 1'b0, 1'b0);
        add_row(pprb_pkg::ACT_READ,    32'h0000_0000, 8'h00, 12'd0,    16'h0000, 1'b0, 1'b0);
        add_row(pprb_pkg::ACT_READ,    32'hFFFF_FFFF, 8'hFF, 12'hFFF,  16'hFFFF, 1'b1, 1'b0);
        add_row(pprb_pkg::ACT_READ,    32'h0000_0000, 8'h00, 12'd0,    16'h0000, 1'b0, 1'b0);
        add_row(pprb_pkg::ACT_READ,    32'h0000_0000, 8'h00, 12'd0,    16'h0000, 1'b0, 1'b0);
        add_row(pprb_pkg::ACT_READ,    32'h0000_0000, 8'h00, 12'd0,    16'h0000, 1'b0, 1'b0);
        add_row(pprb_pkg::ACT_ARRIVAL, 32'h0000_0002, 8'h3C, 12'd100,  16'h1234, 1'b0, 1'b0);
        add_row(pprb_pkg::ACT_READ,    32'h0000_0000, 8'h00, 12'd0,    16'h0000, 1'b1, 1'b0);
        add_row(pprb_pkg::ACT_READ,    32'h0000_0000, 8'h00, 12'd0,    16'h0000, 1'b1, 1'b0);
        add_row(pprb_pkg::ACT_ARRIVAL, 32'h0000_0003, 8'hC3, 12'd2047, 16'h8000, 1'b0, 1'b0);
        add_row(pprb_pkg::ACT_ARRIVAL, 32'h8000_0000, 8'h81, 12'd2,    16'h0001, 1'b1, 1'b0);
        add_row(pprb_pkg::ACT_READ,    32'h0000_0000, 8'h00, 12'd0,    16'h0000, 1'b0, 1'b0);
        add_row(pprb_pkg::ACT_READ,    32'h0000_0000, 8'h00, 12'd0,    16'h0000, 1'b0, 1'b0);
        add_row(pprb_pkg::ACT_READ,    32'h0000_0000, 8'h00, 12'd0,    16'h0000, 1'b0, 1'b0);
        add_row(pprb_pkg::ACT_READ,    32'h0000_0000, 8'h00, 12'd0,    16'h0000, 1'b1, 1'b0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            push_item(plan[i].it, plan[i].typed);

        write_own_address(32'hFFFF_FFFF);
        run_traffic(150);

        write_own_address($urandom);
        run_traffic(150);

        // The output side holds off while reads keep coming, so the block backs up.
        write_own_address(32'h0000_0000);
        @(posedge clk);
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        for (k = 0; k < 40; k++)
            push_item(make_read(1'b0), 1'b0);
        no_gaps = 1'b0;
        run_traffic(150);

        write_own_address(32'h8000_0001);
        for (k = 0; k < 140; k++)
            push_item(make_read(1'b0), 1'b0);
        run_traffic(150);

        settle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
